### rtl/scd_pkg.sv
package scd_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int FILL_W    = $clog2(WIN_DEPTH);

    typedef logic [7:0]        t_byte;
    typedef logic [FILL_W-1:0] t_fill;

    // Input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Protocol modes
    localparam logic MODE_CHECKSUM = 1'b0;
    localparam logic MODE_INVERT   = 1'b1;

    // Configuration register indexes
    localparam logic REG_PROTOCOL_MODE = 1'b0;
    localparam logic REG_HEADER_BITS   = 1'b1;

    // Fill count before the byte that completes a frame
    localparam t_fill FILL_CHECKSUM_LAST = t_fill'(3);
    localparam t_fill FILL_INVERT_LAST   = t_fill'(WIN_DEPTH - 1);

    localparam t_byte SYNC_BYTE = 8'hFF;

    typedef struct packed {
        logic  command;
        t_byte rx_byte;
        logic  line_error;
    } t_item;

    typedef struct packed {
        t_byte command;
        t_byte id;
        t_byte value;
    } t_frame;

endpackage

### rtl/scd_in_reg.sv
module scd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scd_pkg::t_item i_item,
    input  logic           i_hold,
    output logic           o_fire,
    output scd_pkg::t_item o_item
);
    import scd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_fire  = r_valid && !i_hold;
    assign o_ready = !r_valid || !i_hold;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/scd_parse.sv
module scd_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  scd_pkg::t_item  i_item,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [4:0]      i_cfg_data,
    output logic            o_res_valid,
    output scd_pkg::t_frame o_frame
);
    import scd_pkg::*;

    logic       r_mode;
    logic [4:0] r_header;
    t_fill      r_fill;
    t_byte      r_window [WIN_DEPTH];

    logic       n_mode;
    logic [4:0] n_header;
    t_fill      n_fill;
    t_byte      n_window [WIN_DEPTH];

    t_byte      cand [WIN_DEPTH];
    logic       full;
    logic       ok_sum;
    logic       ok_inv;
    logic       ok;
    logic       is_byte;

    // Window with the new byte dropped in at the fill position
    always_comb begin
        cand           = r_window;
        cand[r_fill]   = i_item.rx_byte;
    end

    assign full   = (r_mode == MODE_INVERT) ? (r_fill == FILL_INVERT_LAST)
                                            : (r_fill == FILL_CHECKSUM_LAST);
    assign ok_sum = (cand[0][7:3] == r_header)
                 && ((cand[0] ^ cand[1] ^ cand[2] ^ cand[3]) == '0);
    assign ok_inv = (cand[0] == SYNC_BYTE) && (cand[1] == SYNC_BYTE)
                 && ((cand[2] ^ cand[3]) == SYNC_BYTE)
                 && ((cand[4] ^ cand[5]) == SYNC_BYTE)
                 && ((cand[6] ^ cand[7]) == SYNC_BYTE);
    assign ok      = (r_mode == MODE_INVERT) ? ok_inv : ok_sum;
    assign is_byte = (i_item.command == CMD_BYTE) && !i_item.line_error;

    assign o_res_valid = i_fire && is_byte && full && ok;

    always_comb begin
        if (r_mode == MODE_INVERT) begin
            o_frame.command = cand[2];
            o_frame.id      = cand[4];
            o_frame.value   = cand[6];
        end else begin
            o_frame.command = cand[0];
            o_frame.id      = cand[1];
            o_frame.value   = cand[2];
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_header = r_header;
        n_fill   = r_fill;
        n_window = r_window;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROTOCOL_MODE: begin
                    n_mode = i_cfg_data[0];
                    n_fill = '0;
                end
                REG_HEADER_BITS: begin
                    n_header = i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (i_fire) begin
            priority if (i_item.command == CMD_FLUSH) begin
                n_fill = '0;
            end else if (i_item.line_error) begin
                // drop the word
            end else if (full && ok) begin
                n_fill = '0;
            end else if (full) begin
                // slide out the oldest byte, fill count stays
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    n_window[i] = cand[i + 1];
                end
                n_window[WIN_DEPTH - 1] = '0;
            end else begin
                n_window = cand;
                n_fill   = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CHECKSUM;
            r_header <= '0;
            r_fill   <= '0;
        end else begin
            r_mode   <= n_mode;
            r_header <= n_header;
            r_fill   <= n_fill;
        end
    end

    // Entries at or above the fill count are never read
    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

endmodule

### rtl/scd_out_buf.sv
module scd_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    input  scd_pkg::t_frame i_wr_frame,
    output logic            o_skid_full,
    output logic            o_valid,
    input  logic            i_ready,
    output scd_pkg::t_frame o_frame
);
    import scd_pkg::*;

    logic   r_out_valid;
    t_frame r_out;
    logic   r_skid_valid;
    t_frame r_skid;
    logic   open;

    assign open        = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_frame     = r_out;
    assign o_skid_full = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (open) begin
            // skid word goes first; upstream is held while skid is full
            r_out_valid  <= r_skid_valid || i_wr_valid;
            r_skid_valid <= 1'b0;
        end else if (i_wr_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (open) begin
            r_out <= r_skid_valid ? r_skid : i_wr_frame;
        end else if (i_wr_valid) begin
            r_skid <= i_wr_frame;
        end
    end

endmodule

### rtl/serial_command_deframer.sv
// A word accepted into the input register passes the parser; a completed
// frame is registered in the output register, which drives o_out_valid.
// Throughput: one word per cycle unless the skid is full; the input register
// and the one-deep output skid let a new word in while a frame waits.
// Reset (i_rst_n low, synchronous) empties the pipeline and the byte window
// and returns to checksum mode with a zero header.
module serial_command_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    input  logic       i_line_error,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_command,
    output logic [7:0] o_frame_id,
    output logic [7:0] o_frame_value,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    import scd_pkg::*;

    t_item  in_item;
    t_item  s1_item;
    logic   s1_fire;
    logic   skid_full;
    logic   res_valid;
    t_frame res_frame;
    t_frame out_frame;

    assign in_item.command    = i_command;
    assign in_item.rx_byte    = i_rx_byte;
    assign in_item.line_error = i_line_error;

    scd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_hold  (skid_full),
        .o_fire  (s1_fire),
        .o_item  (s1_item)
    );

    scd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_item      (s1_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_frame     (res_frame)
    );

    scd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_valid  (res_valid),
        .i_wr_frame  (res_frame),
        .o_skid_full (skid_full),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_frame     (out_frame)
    );

    assign o_frame_command = out_frame.command;
    assign o_frame_id      = out_frame.id;
    assign o_frame_value   = out_frame.value;

endmodule

### rtl/scd_checker.sv
module scd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    input  logic       i_line_error,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] o_frame_command,
    input  logic [7:0] o_frame_id,
    input  logic [7:0] o_frame_value,
    input  logic       i_cfg_we
);

    // Reset empties the output and opens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // Input backpressure only while a frame is waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no frame pending");

    // A stalled frame holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_command)
            && $stable(o_frame_id) && $stable(o_frame_value))
        else $error("output frame changed while stalled");

    // A waiting input word holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_command)
            && $stable(i_rx_byte) && $stable(i_line_error))
        else $error("input word changed while waiting");

    // Register writes only with the pipeline idle
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_out_valid && !i_in_valid)
        else $error("register write while words in flight");

endmodule

bind serial_command_deframer scd_checker u_scd_checker (.*);

### tb/sv/tb_serial_command_deframer.sv
`timescale 1ns / 1ps

module tb_serial_command_deframer;
    import scd_pkg::*;

    localparam int      DRAIN_CYCLES = 8;
    localparam int      SEG_COUNT    = 6;
    localparam int      SEG_WORDS    = 134;
    localparam longint  LIMIT_NS     = 3_000_000;
    localparam t_frame  NO_FRAME     = 24'h000000;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       cmd;
        t_byte      rx;
        logic       err;
        logic       idx;
        logic [4:0] data;
        logic       typed;
        t_frame     frame;
    } t_row;

    localparam t_row PLAN [26] = '{
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b1, 24'h00_00_00},
        '{ROW_REG,  CMD_BYTE,  8'h00, 1'b0, REG_HEADER_BITS,   5'd31, 1'b0, NO_FRAME},
        // bad header first, so the window has to slide; 0x55 is dropped
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hF9, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h55, 1'b1, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h01, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h02, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hFA, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b1, 24'hF9_01_02},
        // flush carrying a line error must still empty the window
        '{ROW_WORD, CMD_BYTE,  8'hF8, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hFF, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h07, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_FLUSH, 8'hAB, 1'b1, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_REG,  CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd1,  1'b0, NO_FRAME},
        '{ROW_REG,  CMD_BYTE,  8'h00, 1'b0, REG_HEADER_BITS,   5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hFF, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hFF, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hFF, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h80, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h7F, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'hFF, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b0, NO_FRAME},
        '{ROW_WORD, CMD_BYTE,  8'h00, 1'b0, REG_PROTOCOL_MODE, 5'd0,  1'b1, 24'h00_80_FF}
    };

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       i_command       = CMD_BYTE;
    logic [7:0] i_rx_byte       = 8'h00;
    logic       i_line_error    = 1'b0;
    logic       i_out_ready     = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic       i_cfg_index     = REG_PROTOCOL_MODE;
    logic [4:0] i_cfg_data      = 5'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_frame_command;
    logic [7:0] o_frame_id;
    logic [7:0] o_frame_value;

    // shadow of the deframer state
    t_byte      win [WIN_DEPTH];
    int         win_fill;
    logic       proto_mode = MODE_CHECKSUM;
    logic [4:0] hdr_bits   = 5'd0;

    t_frame     frames_due [$];
    t_frame     frame_exp;
    int         mismatch_count = 0;
    int         words_sent     = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;

    serial_command_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_rx_byte       (i_rx_byte),
        .i_line_error    (i_line_error),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_command (o_frame_command),
        .o_frame_id      (o_frame_id),
        .o_frame_value   (o_frame_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic void clear_win();
        foreach (win[k]) win[k] = 8'h00;
        win_fill = 0;
    endfunction

    function automatic void drop_oldest();
        for (int k = 0; k < WIN_DEPTH - 1; k++) win[k] = win[k + 1];
        win[WIN_DEPTH - 1] = 8'h00;
        if (win_fill > 0) win_fill--;
    endfunction

    // Advance the shadow window by one word; returns 1 when a frame comes out.
    function automatic bit deframe_word(input logic cmd, input t_byte rx, input logic err,
                                        output t_frame frame);
        int need;
        bit ok;
        frame = NO_FRAME;
        if (cmd == CMD_FLUSH) begin
            clear_win();
            return 1'b0;
        end
        if (err) return 1'b0;
        if (win_fill >= WIN_DEPTH) drop_oldest();
        win[win_fill % WIN_DEPTH] = rx;
        win_fill++;
        need = (proto_mode == MODE_INVERT) ? WIN_DEPTH : int'(FILL_CHECKSUM_LAST) + 1;
        if (win_fill < need) return 1'b0;
        if (proto_mode == MODE_CHECKSUM) begin
            ok = (win[0][7:3] == hdr_bits) && ((win[0] ^ win[1] ^ win[2] ^ win[3]) == 8'h00);
            frame.command = win[0];
            frame.id      = win[1];
            frame.value   = win[2];
        end else begin
            ok = (win[0] == SYNC_BYTE) && (win[1] == SYNC_BYTE) &&
                 ((win[2] ^ win[3]) == 8'hFF) && ((win[4] ^ win[5]) == 8'hFF) &&
                 ((win[6] ^ win[7]) == 8'hFF);
            frame.command = win[2];
            frame.id      = win[4];
            frame.value   = win[6];
        end
        if (ok) clear_win();
        else drop_oldest();
        return ok;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_word(input logic cmd, input t_byte rx, input logic err,
                             input logic typed, input t_frame typed_frame);
        t_frame frame;
        bit     got;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_rx_byte    <= rx;
        i_line_error <= err;
        do @(posedge i_clk); while (!o_in_ready);
        got = deframe_word(cmd, rx, err, frame);
        if (typed) frames_due.push_back(typed_frame);
        else if (got) frames_due.push_back(frame);
        words_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PROTOCOL_MODE) begin
            proto_mode = data[0];
            clear_win();
        end else begin
            hdr_bits = data;
        end
        @(posedge i_clk);
    endtask

    // One random burst: mostly well-formed frames, some corrupted, noise or flush.
    task automatic send_burst();
        t_byte seq [$];
        logic  errq [$];
        int    pick;
        int    pos;
        t_byte c;
        t_byte id;
        t_byte v;
        pick = $urandom_range(99);
        if (pick >= 90) begin
            send_word(CMD_FLUSH, t_byte'($urandom), 1'($urandom_range(1)), 1'b0, NO_FRAME);
        end else if (pick >= 75) begin
            repeat ($urandom_range(1, 5))
                send_word(CMD_BYTE, t_byte'($urandom), ($urandom_range(7) == 0), 1'b0,
                          NO_FRAME);
        end else begin
            c  = t_byte'($urandom);
            id = t_byte'($urandom);
            v  = t_byte'($urandom);
            if (proto_mode == MODE_CHECKSUM) begin
                c = {hdr_bits, 3'($urandom)};
                seq = '{c, id, v, c ^ id ^ v};
            end else begin
                seq = '{SYNC_BYTE, SYNC_BYTE, c, ~c, id, ~id, v, ~v};
            end
            if (pick >= 60) begin
                pos = $urandom_range(seq.size() - 1);
                seq[pos] = seq[pos] ^ (8'h01 << $urandom_range(7));
            end
            foreach (seq[k]) errq.push_back(1'b0);
            if ($urandom_range(4) == 0) begin
                pos = $urandom_range(seq.size());
                seq.insert(pos, t_byte'($urandom));
                errq.insert(pos, 1'b1);
            end
            foreach (seq[k]) send_word(CMD_BYTE, seq[k], errq[k], 1'b0, NO_FRAME);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                $error("unexpected frame: command %02h id %02h value %02h",
                       o_frame_command, o_frame_id, o_frame_value);
                mismatch_count++;
            end else begin
                frame_exp = frames_due.pop_front();
                if (o_frame_command !== frame_exp.command) begin
                    $error("frame_command: expected %02h, got %02h",
                           frame_exp.command, o_frame_command);
                    mismatch_count++;
                end
                if (o_frame_id !== frame_exp.id) begin
                    $error("frame_id: expected %02h, got %02h", frame_exp.id, o_frame_id);
                    mismatch_count++;
                end
                if (o_frame_value !== frame_exp.value) begin
                    $error("frame_value: expected %02h, got %02h",
                           frame_exp.value, o_frame_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_serial_command_deframer: errors");
        $finish;
    end

    initial begin
        int         bursts;
        logic       seg_mode;
        logic [4:0] seg_hdr;
        bursts = 0;
        clear_win();
        send_idle_pct = 17;
        recv_idle_pct = 67;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[k]) begin
            if (PLAN[k].kind == ROW_REG) begin
                wait_idle();
                write_reg(PLAN[k].idx, PLAN[k].data);
            end else begin
                send_word(PLAN[k].cmd, PLAN[k].rx, PLAN[k].err, PLAN[k].typed,
                          PLAN[k].frame);
            end
        end

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seg_mode = (seg == 1 || seg == 3) ? MODE_INVERT : MODE_CHECKSUM;
            if (seg == 0 || seg == 3) seg_hdr = 5'd31;
            else if (seg == 2) seg_hdr = 5'd0;
            else seg_hdr = 5'($urandom_range(31));
            wait_idle();
            // last segment changes the header only, keeping any partial window
            if (seg != SEG_COUNT - 1)
                write_reg(REG_PROTOCOL_MODE, {4'($urandom), seg_mode});
            write_reg(REG_HEADER_BITS, seg_hdr);
            words_sent = 0;
            while (words_sent < SEG_WORDS) begin
                if (bursts == 25 || $urandom_range(199) == 0) wait_idle();
                send_burst();
                bursts++;
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_serial_command_deframer: clean");
        end else begin
            $display("tb_serial_command_deframer: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/scd_pkg.sv
rtl/scd_in_reg.sv
rtl/scd_parse.sv
rtl/scd_out_buf.sv
rtl/serial_command_deframer.sv
rtl/scd_checker.sv
tb/sv/tb_serial_command_deframer.sv
